FILE: hdl/scp_pkg.sv
// Shared types and constants for the serial command parser.
// No dependencies; used by serial_command_parser_top.
package scp_pkg;

	localparam logic [15:0] PWM_FS_RESET = 16'd255;

	// floor(pct * 255 / 100) == (pct * DUTY_RECIP) >> DUTY_SHIFT for pct < 256
	localparam int           DUTY_SHIFT = 16;
	localparam logic [17:0]  DUTY_RECIP = 18'd167117;

	localparam logic REPLY_ACK = 1'b0;
	localparam logic REPLY_ERR = 1'b1;

	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_1 = 8'h31;
	localparam logic [7:0] CH_3 = 8'h33;
	localparam logic [7:0] CH_4 = 8'h34;
	localparam logic [7:0] CH_5 = 8'h35;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_F = 8'h46;
	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_L = 8'h4C;
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_O = 8'h4F;
	localparam logic [7:0] CH_S = 8'h53;

	localparam logic [1:0] MODE_OFF    = 2'd0;
	localparam logic [1:0] MODE_BANNER = 2'd1;
	localparam logic [1:0] MODE_SPEED  = 2'd2;
	localparam logic [1:0] MODE_SPDTMP = 2'd3;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       switch_level;
	} scp_in_t;

	typedef struct packed {
		logic        reply;
		logic        led_on;
		logic        switch_latched;
		logic [3:0]  digit_select;
		logic [6:0]  segment_pattern;
		logic [1:0]  display_mode;
		logic [15:0] fan_duty;
		logic [15:0] heater_duty;
	} scp_out_t;

	// segments g..a for decimal digits
	function automatic logic [6:0] seg_of(input logic [3:0] d);
		logic [6:0] s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h27;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

FILE: hdl/serial_command_parser_top.sv
// Serial command parser: byte-wide command decoder with output registers.
// Depends on scp_pkg.
//
// Usage:
//   in channel (in_valid/in_ready/in_data): one received character per word,
//   with the current switch level alongside.
//   out channel (out_valid/out_ready/out_data): one word per completed command
//   (reply ACK) or per unexpected character (reply ERR, parser back to idle);
//   each word carries all output registers after the character took effect.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): PWM full-scale count, always
//   ready; write only while the parser is quiet.
// Flow: a taken word is held in the input register, decoded there, and its
// result is registered in the result register for out_data. Throughput: one
// word per cycle unless a held result stalls, set by the single decode stage
// between the input register and the result register.
// Reset: idle, out_valid and state zero except display mode 1, full scale 255.
// Stall: a held result keeps the input register full; a word that yields no
// result still passes. in_ready drops only when both registers are full and
// the output is not taken.
module serial_command_parser_top
	import scp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  scp_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output scp_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_L, ST_LS, ST_LC, ST_S, ST_D, ST_DN, ST_LCD, ST_LCDO,
		ST_LCDOF, ST_C, ST_SS, ST_SS1, ST_SS2, ST_H, ST_HS, ST_HS0, ST_HS1
	} state_t;

	state_t      state_q, state_d;
	logic [7:0]  acc_q, acc_d;
	logic [1:0]  chosen_q, chosen_d;
	logic        led_q, led_d;
	logic        sw_q, sw_d;
	logic [3:0]  sel_q, sel_d;
	logic [6:0]  pat_q, pat_d;
	logic [1:0]  mode_q, mode_d;
	logic [15:0] fan_q, fan_d;
	logic [15:0] heat_q, heat_d;
	logic [15:0] fs_q;

	logic        valid_s1;
	scp_in_t     item_s1;
	logic        out_valid_q;
	scp_out_t    out_q;

	logic        ack, err, has_result, adv_s1;
	logic [7:0]  c;
	logic [3:0]  dig;
	logic [7:0]  pct;
	logic [25:0] prod;
	logic [8:0]  scaled;
	logic [15:0] duty;

	assign c   = item_s1.rx_byte;
	assign dig = c[3:0];
	assign pct = acc_q + {4'd0, dig};

	assign prod   = {18'd0, pct} * {8'd0, DUTY_RECIP};
	assign scaled = prod[DUTY_SHIFT +: 9];
	assign duty   = ({7'd0, scaled} > fs_q) ? fs_q : {7'd0, scaled};

	always_comb begin
		state_d  = ST_IDLE;
		acc_d    = acc_q;
		chosen_d = chosen_q;
		led_d    = led_q;
		sw_d     = sw_q;
		sel_d    = sel_q;
		pat_d    = pat_q;
		mode_d   = mode_q;
		fan_d    = fan_q;
		heat_d   = heat_q;
		ack      = 1'b0;
		err      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (c == CH_L) state_d = ST_L;
				else if (c == CH_S) state_d = ST_S;
				else if (c == CH_D) state_d = ST_D;
				else if (c == CH_C) state_d = ST_C;
				else if (c == CH_H) state_d = ST_H;
				else err = 1'b1;
			end
			ST_L: begin
				if (c == CH_S) state_d = ST_LS;
				else if (c == CH_C) state_d = ST_LC;
				else err = 1'b1;
			end
			ST_LS: begin
				if (c == CH_4) begin
					led_d = 1'b1;
					ack   = 1'b1;
				end else err = 1'b1;
			end
			ST_LC: begin
				if (c == CH_4) begin
					led_d = 1'b0;
					ack   = 1'b1;
				end else if (c == CH_D) state_d = ST_LCD;
				else err = 1'b1;
			end
			ST_S: begin
				if (c == CH_3) begin
					sw_d = item_s1.switch_level;
					ack  = 1'b1;
				end else if (c == CH_S) state_d = ST_SS;
				else err = 1'b1;
			end
			ST_D: begin
				if (c inside {[CH_1:CH_4]}) begin
					chosen_d = c[1:0] - 2'd1;
					state_d  = ST_DN;
				end else err = 1'b1;
			end
			ST_DN: begin
				if (c == CH_C) begin
					sel_d = 4'd0;
					pat_d = 7'd0;
					ack   = 1'b1;
				end else if (c inside {[CH_0:CH_9]}) begin
					sel_d = 4'b1000 >> chosen_q;
					pat_d = seg_of(dig);
					ack   = 1'b1;
				end else err = 1'b1;
			end
			ST_LCD: begin
				if (c == CH_O) state_d = ST_LCDO;
				else err = 1'b1;
			end
			ST_LCDO: begin
				if (c == CH_N) begin
					mode_d = MODE_BANNER;
					ack    = 1'b1;
				end else if (c == CH_F) state_d = ST_LCDOF;
				else err = 1'b1;
			end
			ST_LCDOF: begin
				if (c == CH_F) begin
					mode_d = MODE_OFF;
					ack    = 1'b1;
				end else err = 1'b1;
			end
			ST_C: begin
				if (c == CH_S) begin
					mode_d = MODE_SPEED;
					ack    = 1'b1;
				end else err = 1'b1;
			end
			ST_SS: begin
				if (c inside {[CH_0:CH_1]}) begin
					acc_d   = c[0] ? 8'd100 : 8'd0;
					state_d = ST_SS1;
				end else err = 1'b1;
			end
			ST_SS1: begin
				if (c inside {[CH_0:CH_9]}) begin
					acc_d   = acc_q + {dig, 3'b000} + {3'd0, dig, 1'b0};
					state_d = ST_SS2;
				end else err = 1'b1;
			end
			ST_SS2: begin
				if (c inside {[CH_0:CH_9]}) begin
					fan_d  = duty;
					mode_d = MODE_OFF;
					ack    = 1'b1;
				end else err = 1'b1;
			end
			ST_H: begin
				if (c == CH_S) state_d = ST_HS;
				else if (c == CH_C) begin
					mode_d = MODE_SPDTMP;
					ack    = 1'b1;
				end else err = 1'b1;
			end
			ST_HS: begin
				if (c == CH_0) begin
					acc_d   = 8'd0;
					state_d = ST_HS0;
				end else err = 1'b1;
			end
			ST_HS0: begin
				if (c inside {[CH_0:CH_5]}) begin
					acc_d   = {1'b0, dig, 3'b000} + {3'd0, dig, 1'b0};
					state_d = ST_HS1;
				end else err = 1'b1;
			end
			ST_HS1: begin
				if (c inside {[CH_0:CH_9]}) begin
					heat_d = duty;
					mode_d = MODE_OFF;
					ack    = 1'b1;
				end else err = 1'b1;
			end
			default: err = 1'b1;
		endcase
	end

	assign has_result = ack | err;
	assign adv_s1     = valid_s1 & (~out_valid_q | out_ready | ~has_result);
	assign in_ready   = ~valid_s1 | adv_s1;
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= ST_IDLE;
			acc_q       <= 8'd0;
			chosen_q    <= 2'd0;
			led_q       <= 1'b0;
			sw_q        <= 1'b0;
			sel_q       <= 4'd0;
			pat_q       <= 7'd0;
			mode_q      <= MODE_BANNER;
			fan_q       <= 16'd0;
			heat_q      <= 16'd0;
			fs_q        <= PWM_FS_RESET;
		end else begin
			if (cfg_valid) fs_q <= cfg_data;
			if (in_ready) valid_s1 <= in_valid;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (adv_s1) begin
				state_q  <= state_d;
				acc_q    <= acc_d;
				chosen_q <= chosen_d;
				led_q    <= led_d;
				sw_q     <= sw_d;
				sel_q    <= sel_d;
				pat_q    <= pat_d;
				mode_q   <= mode_d;
				fan_q    <= fan_d;
				heat_q   <= heat_d;
				if (has_result) out_valid_q <= 1'b1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_data;
		if (adv_s1 && has_result) begin
			out_q.reply           <= err ? REPLY_ERR : REPLY_ACK;
			out_q.led_on          <= led_d;
			out_q.switch_latched  <= sw_d;
			out_q.digit_select    <= sel_d;
			out_q.segment_pattern <= pat_d;
			out_q.display_mode    <= mode_d;
			out_q.fan_duty        <= fan_d;
			out_q.heater_duty     <= heat_d;
		end
	end

endmodule
